@@ hdl/scl_pkg.sv @@
package scl_pkg;

  localparam int LINE_CHARS = 32;
  localparam int COUNT_W    = $clog2(LINE_CHARS);

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_R     = 8'h52;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_M     = 8'h4d;

  typedef enum logic [2:0] {
    CMD_NULL,
    CMD_STOP,
    CMD_REL,
    CMD_RATE,
    CMD_ABS
  } cmd_t;

  function automatic cmd_t decode_letter(logic [7:0] c);
    cmd_t r;
    case (c)
      CHAR_S:  r = CMD_STOP;
      CHAR_R:  r = CMD_REL;
      CHAR_F:  r = CMD_RATE;
      CHAR_M:  r = CMD_ABS;
      default: r = CMD_NULL;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/serial_command_line_parser.sv @@
// A byte is first captured in the input register, then parsed from there;
// a newline's result is then registered in the result register with out_valid.
// Throughput: one byte per cycle; a newline waits only while an earlier
// result is still stalled in the result register.
// Reset: synchronous, active high; clears both stages and the line state
// (no command, skipping whitespace, zero value).
module serial_command_line_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output scl_pkg::cmd_t       command,
  output logic signed [15:0]  argument
);
  import scl_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  logic               in_full;
  logic [7:0]         in_byte;

  logic [COUNT_W-1:0] char_count, char_count_next;
  cmd_t               command_code, command_code_next;
  phase_t             parse_phase, parse_phase_next;
  logic               negative_flag, negative_flag_next;
  logic [15:0]        accumulator, accumulator_next;

  logic               is_nl;
  logic               is_digit;
  logic               is_blank;
  logic               advance;
  logic [15:0]        arg_value;

  assign is_nl    = (in_byte == CHAR_NL);
  assign is_digit = in_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign is_blank = in_byte inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
  assign advance  = in_full && (!is_nl || !out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_comb begin
    if (command_code == CMD_NULL || command_code == CMD_STOP) begin
      arg_value = 16'd0;
    end else if (negative_flag) begin
      arg_value = 16'd0 - accumulator;
    end else begin
      arg_value = accumulator;
    end
  end

  always_comb begin
    char_count_next    = char_count;
    command_code_next  = command_code;
    parse_phase_next   = parse_phase;
    negative_flag_next = negative_flag;
    accumulator_next   = accumulator;
    if (is_nl) begin
      char_count_next    = '0;
      command_code_next  = CMD_NULL;
      parse_phase_next   = PH_SKIP;
      negative_flag_next = 1'b0;
      accumulator_next   = 16'd0;
    end else if (char_count < COUNT_W'(LINE_CHARS - 1)) begin
      char_count_next = char_count + COUNT_W'(1);
      if (char_count == '0) begin
        command_code_next = decode_letter(in_byte);
      end else if (parse_phase != PH_DONE) begin
        if (is_digit) begin
          accumulator_next = (accumulator << 3) + (accumulator << 1)
                             + {12'd0, in_byte[3:0]};
          parse_phase_next = PH_DIGITS;
        end else if (parse_phase == PH_SKIP && is_blank) begin
          parse_phase_next = PH_SKIP;
        end else if (parse_phase == PH_SKIP && in_byte == CHAR_MINUS) begin
          negative_flag_next = 1'b1;
          parse_phase_next   = PH_SIGN;
        end else if (parse_phase == PH_SKIP && in_byte == CHAR_PLUS) begin
          parse_phase_next = PH_SIGN;
        end else begin
          parse_phase_next = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      char_count    <= '0;
      command_code  <= CMD_NULL;
      parse_phase   <= PH_SKIP;
      negative_flag <= 1'b0;
      accumulator   <= 16'd0;
    end else begin
      if (!in_stall) begin
        in_full <= in_valid;
        if (in_valid) begin
          in_byte <= rx_byte;
        end
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        char_count    <= char_count_next;
        command_code  <= command_code_next;
        parse_phase   <= parse_phase_next;
        negative_flag <= negative_flag_next;
        accumulator   <= accumulator_next;
        if (is_nl) begin
          out_valid <= 1'b1;
          command   <= command_code;
          argument  <= arg_value;
        end
      end
    end
  end

  a_nl_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance && is_nl |=> out_valid)
    else $error("newline beat gave no result");

  a_nl_clears_line: assert property (@(posedge clk) disable iff (rst)
    advance && is_nl |=> char_count == '0 && parse_phase == PH_SKIP
                         && command_code == CMD_NULL && accumulator == 16'd0)
    else $error("line state not cleared after newline");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= COUNT_W'(LINE_CHARS - 1))
    else $error("character count past line limit");

  a_zero_arg: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_NULL || command == CMD_STOP) |-> argument == 16'sd0)
    else $error("argument not zero for none or stop");

  a_nl_held: assert property (@(posedge clk) disable iff (rst)
    in_full && is_nl && out_valid && out_stall |-> in_stall)
    else $error("newline parsed over a stalled result");

endmodule
